>>> sv/flow_class_buffer_admission_core_macros.svh
// Assertion macros for the buffer admission core checker.
`ifndef FLOW_CLASS_BUFFER_ADMISSION_CORE_MACROS_SVH
`define FLOW_CLASS_BUFFER_ADMISSION_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define FCBA_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/fcba_pkg.sv
// Shared types and constants of the buffer admission core.
`default_nettype none
package fcba_pkg;

    localparam int SIZE_W    = 16;
    localparam int ID_W      = 16;
    localparam int LIM_W     = 16;
    localparam int REG_W     = 24;
    localparam int OUT_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [REG_W-1:0] BUFFER_BYTES_RST   = 24'd262144;
    localparam logic [REG_W-1:0] INIT_THRESHOLD_RST = 24'd262144;
    localparam logic [LIM_W-1:0] SMALL_LIMIT_RST    = 16'd500;
    localparam logic [LIM_W-1:0] LONG_ID_LIMIT_RST  = 16'd15;
    localparam logic [REG_W-1:0] FLOOR_RST          = 24'd30720;

    typedef enum logic [2:0] {
        VERDICT_SMALL        = 3'd0,
        VERDICT_ADMITTED     = 3'd1,
        VERDICT_DROP_FULL    = 3'd2,
        VERDICT_DROP_LONG    = 3'd3,
        VERDICT_DEPARTED     = 3'd4,
        VERDICT_DEPART_SMALL = 3'd5
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUFFER_BYTES   = 3'd0,
        REG_INIT_THRESHOLD = 3'd1,
        REG_SMALL_LIMIT    = 3'd2,
        REG_LONG_ID_LIMIT  = 3'd3,
        REG_FLOOR          = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic              depart;
        logic              is_small;
        logic              is_long;
        logic [SIZE_W-1:0] size;
    } cmd_t;

    typedef struct packed {
        logic [REG_W-1:0] buffer_bytes;
        logic [REG_W-1:0] threshold_floor;
    } acct_cfg_t;

endpackage
`default_nettype wire

>>> sv/fcba_front.sv
// Front end: accept and classify items, queue them for the accounting stage.
`default_nettype none
module fcba_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        command,
    input  wire logic [fcba_pkg::SIZE_W-1:0] pkt_size,
    input  wire logic [fcba_pkg::ID_W-1:0]   flow_id,
    input  wire logic [fcba_pkg::LIM_W-1:0]  small_limit,
    input  wire logic [fcba_pkg::LIM_W-1:0]  long_id_limit,
    output logic                             cmd_valid,
    input  wire logic                        cmd_ready,
    output fcba_pkg::cmd_t                   cmd
);

    fcba_pkg::cmd_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    fcba_pkg::cmd_t class_cmd;
    logic           push, pop;

    always_comb begin
        class_cmd.depart   = command;
        class_cmd.is_small = (pkt_size < small_limit);
        class_cmd.is_long  = (flow_id < long_id_limit);
        class_cmd.size     = pkt_size;
    end

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= class_cmd;
        end
    end

endmodule
`default_nettype wire

>>> sv/fcba_back.sv
// Back end: byte accounting, admission decision and output register.
`default_nettype none
module fcba_back #(
    parameter int W = 24
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  wire fcba_pkg::cmd_t             cmd,
    input  wire fcba_pkg::acct_cfg_t        cfg,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output fcba_pkg::verdict_t              verdict,
    output logic [fcba_pkg::OUT_W-1:0]      used_total,
    output logic [fcba_pkg::OUT_W-1:0]      used_long,
    output logic [fcba_pkg::OUT_W-1:0]      used_short,
    output logic [fcba_pkg::OUT_W-1:0]      long_threshold
);

    localparam int XW = ((W > fcba_pkg::REG_W) ? W : fcba_pkg::REG_W) + 1;
    localparam logic [XW-1:0] CNT_MAX_X = {{(XW-W){1'b0}}, {W{1'b1}}};
    localparam logic [XW-1:0] INIT_X    = XW'(fcba_pkg::INIT_THRESHOLD_RST);
    localparam logic [W-1:0]  LL_RST    =
        (INIT_X > CNT_MAX_X) ? CNT_MAX_X[W-1:0] : INIT_X[W-1:0];

    function automatic logic [W-1:0] sat_w(input logic [XW-1:0] v);
        sat_w = (v > CNT_MAX_X) ? CNT_MAX_X[W-1:0] : v[W-1:0];
    endfunction

    function automatic logic [XW-1:0] sub_sat(input logic [XW-1:0] a,
                                              input logic [XW-1:0] b);
        sub_sat = (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [fcba_pkg::OUT_W-1:0] to_out(input logic [W-1:0] v);
        logic [XW-1:0] t;
        t      = XW'(v);
        to_out = t[fcba_pkg::OUT_W-1:0];
    endfunction

    logic [W-1:0]       total_reg, total_next;
    logic [W-1:0]       long_reg, long_next;
    logic [W-1:0]       short_reg, short_next;
    logic [W-1:0]       limit_reg, limit_next;
    logic               valid_reg;
    fcba_pkg::verdict_t verdict_reg, verdict_next;
    logic [fcba_pkg::OUT_W-1:0] tot_out_reg, long_out_reg, short_out_reg, lim_out_reg;

    logic [XW-1:0] tot_x, lu_x, su_x, ll_x, size_x, buf_x, floor_x;
    logic [XW-1:0] sum_t, sum_l, sum_s, tn_x, room_x;
    logic [W-1:0]  tot_add;
    logic          pop;

    assign cmd_ready = !valid_reg || out_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        tot_x   = XW'(total_reg);
        lu_x    = XW'(long_reg);
        su_x    = XW'(short_reg);
        ll_x    = XW'(limit_reg);
        size_x  = XW'(cmd.size);
        buf_x   = XW'(cfg.buffer_bytes);
        floor_x = XW'(cfg.threshold_floor);
        sum_t   = tot_x + size_x;
        sum_l   = lu_x + size_x;
        sum_s   = su_x + size_x;
        tot_add = sat_w(sum_t);
        tn_x    = XW'(tot_add);
        room_x  = sub_sat(buf_x, tn_x);
        if (room_x <= floor_x) begin
            room_x = floor_x;
        end

        total_next   = total_reg;
        long_next    = long_reg;
        short_next   = short_reg;
        limit_next   = limit_reg;
        verdict_next = fcba_pkg::VERDICT_SMALL;

        if (!cmd.depart) begin
            if (cmd.is_small) begin
                verdict_next = fcba_pkg::VERDICT_SMALL;
            end else if (!(buf_x > sum_t)) begin
                verdict_next = fcba_pkg::VERDICT_DROP_FULL;
            end else if (cmd.is_long && (sum_l > ll_x)) begin
                verdict_next = fcba_pkg::VERDICT_DROP_LONG;
            end else begin
                verdict_next = fcba_pkg::VERDICT_ADMITTED;
                total_next   = tot_add;
                limit_next   = sat_w(room_x);
                if (cmd.is_long) begin
                    long_next = sat_w(sum_l);
                end else begin
                    short_next = sat_w(sum_s);
                end
            end
        end else begin
            if (cmd.is_small) begin
                verdict_next = fcba_pkg::VERDICT_DEPART_SMALL;
            end else begin
                verdict_next = fcba_pkg::VERDICT_DEPARTED;
                total_next   = W'(sub_sat(tot_x, size_x));
                if (cmd.is_long) begin
                    long_next = W'(sub_sat(lu_x, size_x));
                end else begin
                    short_next = W'(sub_sat(su_x, size_x));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            long_reg  <= '0;
            short_reg <= '0;
            limit_reg <= LL_RST;
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                total_reg <= total_next;
                long_reg  <= long_next;
                short_reg <= short_next;
                limit_reg <= limit_next;
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            verdict_reg   <= verdict_next;
            tot_out_reg   <= to_out(total_next);
            long_out_reg  <= to_out(long_next);
            short_out_reg <= to_out(short_next);
            lim_out_reg   <= to_out(limit_next);
        end
    end

    assign out_valid      = valid_reg;
    assign verdict        = verdict_reg;
    assign used_total     = tot_out_reg;
    assign used_long      = long_out_reg;
    assign used_short     = short_out_reg;
    assign long_threshold = lim_out_reg;

endmodule
`default_nettype wire

>>> sv/flow_class_buffer_admission_core.sv
// Top level of the two-class shared-buffer admission core.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tdata {flow_id, pkt_size}, s_tuser command
//  m_       out        m_tvalid / m_tready  m_tdata {long_threshold .. used_total},
//                                           m_tuser verdict
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while m_tready is high; an s_ transfer reaches m_tvalid
// through the two-entry queue, then the accounting update and output register.
// aresetn is synchronous: counters clear, threshold loads its reset value.
// A stalled m_ side fills the queue, then drops s_tready; cfg_ready is always high.
`default_nettype none
module flow_class_buffer_admission_core #(
    parameter int BYTE_COUNT_BITS = 24
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [31:0]                     s_tdata,   // pkt_size, flow_id
    input  wire logic                            s_tuser,   // command
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [95:0]                          m_tdata,   // used_total, used_long,
                                                            // used_short, long_threshold
    output logic [2:0]                           m_tuser,   // verdict
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fcba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fcba_pkg::REG_W-1:0]      cfg_data
);

    logic [fcba_pkg::REG_W-1:0] buffer_reg;
    logic [fcba_pkg::LIM_W-1:0] small_reg;
    logic [fcba_pkg::LIM_W-1:0] long_id_reg;
    logic [fcba_pkg::REG_W-1:0] floor_reg;

    fcba_pkg::cmd_t      cmd;
    logic                cmd_valid, cmd_ready;
    fcba_pkg::acct_cfg_t acct_cfg;
    fcba_pkg::verdict_t  verdict;
    logic [fcba_pkg::OUT_W-1:0] used_total, used_long, used_short, long_threshold;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_reg  <= fcba_pkg::BUFFER_BYTES_RST;
            small_reg   <= fcba_pkg::SMALL_LIMIT_RST;
            long_id_reg <= fcba_pkg::LONG_ID_LIMIT_RST;
            floor_reg   <= fcba_pkg::FLOOR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fcba_pkg::REG_BUFFER_BYTES:   buffer_reg  <= cfg_data;
                fcba_pkg::REG_INIT_THRESHOLD: ;
                fcba_pkg::REG_SMALL_LIMIT:    small_reg   <= cfg_data[fcba_pkg::LIM_W-1:0];
                fcba_pkg::REG_LONG_ID_LIMIT:  long_id_reg <= cfg_data[fcba_pkg::LIM_W-1:0];
                fcba_pkg::REG_FLOOR:          floor_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign acct_cfg.buffer_bytes    = buffer_reg;
    assign acct_cfg.threshold_floor = floor_reg;

    fcba_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .command       (s_tuser),
        .pkt_size      (s_tdata[15:0]),
        .flow_id       (s_tdata[31:16]),
        .small_limit   (small_reg),
        .long_id_limit (long_id_reg),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    fcba_back #(
        .W (BYTE_COUNT_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .cfg            (acct_cfg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .verdict        (verdict),
        .used_total     (used_total),
        .used_long      (used_long),
        .used_short     (used_short),
        .long_threshold (long_threshold)
    );

    assign m_tuser = verdict;
    assign m_tdata = {long_threshold, used_short, used_long, used_total};

endmodule
`default_nettype wire

>>> sv/fcba_checker.sv
// Port-level checker of the admission core, bound to the top level.
`default_nettype none
`include "flow_class_buffer_admission_core_macros.svh"
module fcba_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    `FCBA_ASSERT_NEXT_ALWAYS(a_reset_empties, !aresetn, !m_tvalid, "result valid after reset")
    `FCBA_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `FCBA_ASSERT_NOW(a_result_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without transfer two cycles before")

endmodule

bind flow_class_buffer_admission_core fcba_checker u_fcba_checker (.*);
`default_nettype wire
